>>> sv/tcd_pkg.sv
// ---------------------------------------------------------------------------
// tcd_pkg
// Shared codes and types for the text charset detector.
// ---------------------------------------------------------------------------
package tcd_pkg;

   localparam int DataWidth    = 8;
   localparam int CharsetWidth = 3;

   localparam logic [CharsetWidth-1:0] CharsetUnknown = 3'd0;
   localparam logic [CharsetWidth-1:0] CharsetAnsi    = 3'd1;
   localparam logic [CharsetWidth-1:0] CharsetUtf8    = 3'd2;
   localparam logic [CharsetWidth-1:0] CharsetUtf16le = 3'd3;
   localparam logic [CharsetWidth-1:0] CharsetUtf16be = 3'd4;

   typedef struct packed {
      logic                    utf16be_valid;
      logic                    utf16le_valid;
      logic                    utf8_valid;
      logic                    gbk_valid;
      logic                    ascii_valid;
      logic [CharsetWidth-1:0] charset;
   } result_type;

endpackage

>>> sv/tcd_validate.sv
// ---------------------------------------------------------------------------
// tcd_validate
// Five byte-wise validators with their state, and the class of the buffer
// as seen after the current byte.
// ---------------------------------------------------------------------------
module tcd_validate (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [tcd_pkg::DataWidth-1:0]  data_byte,
   input  logic                           last_byte,
   output tcd_pkg::result_type            result
);

   logic       ascii_ok_ff,  ascii_ok_in;
   logic       gbk_ok_ff,    gbk_ok_in;
   logic       gbk_trail_ff, gbk_trail_in;
   logic       utf8_ok_ff,   utf8_ok_in;
   logic [1:0] utf8_left_ff, utf8_left_in;
   logic       parity_ff,    parity_in;
   logic       le_ok_ff,     le_ok_in;
   logic       le_low_ff,    le_low_in;
   logic       be_ok_ff,     be_ok_in;
   logic       be_low_ff,    be_low_in;

   logic       av, gv, uv, lv, bv;
   logic       is_high, is_low;

   always_comb begin
      ascii_ok_in  = ascii_ok_ff & ~data_byte[7];

      gbk_ok_in    = gbk_ok_ff;
      gbk_trail_in = gbk_trail_ff;
      if (gbk_trail_ff) begin
         if (data_byte < 8'h40 || data_byte == 8'hFF) begin
            gbk_ok_in = 1'b0;
         end
         gbk_trail_in = 1'b0;
      end else if (data_byte[7]) begin
         if (data_byte != 8'h80 && data_byte != 8'hFF) begin
            gbk_trail_in = 1'b1;
         end else begin
            gbk_ok_in = 1'b0;
         end
      end

      utf8_ok_in   = utf8_ok_ff;
      utf8_left_in = utf8_left_ff;
      if (utf8_left_ff != 2'd0) begin
         if (data_byte[7:6] == 2'b10) begin
            utf8_left_in = utf8_left_ff - 2'd1;
         end else begin
            utf8_ok_in   = 1'b0;
            utf8_left_in = 2'd0;
         end
      end else if (!data_byte[7]) begin
         utf8_left_in = 2'd0;
      end else if (data_byte[7:5] == 3'b110) begin
         utf8_left_in = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
         utf8_left_in = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
         utf8_left_in = 2'd3;
      end else begin
         utf8_ok_in = 1'b0;
      end

      is_high   = (data_byte[7:2] == 6'b110110);
      is_low    = (data_byte[7:2] == 6'b110111);
      le_ok_in  = le_ok_ff;
      le_low_in = le_low_ff;
      be_ok_in  = be_ok_ff;
      be_low_in = be_low_ff;
      if (parity_ff) begin
         if (le_low_ff) begin
            if (is_low) le_low_in = 1'b0;
            else        le_ok_in  = 1'b0;
         end else if (is_high) begin
            le_low_in = 1'b1;
         end else if (is_low) begin
            le_ok_in = 1'b0;
         end
      end else begin
         if (be_low_ff) begin
            if (is_low) be_low_in = 1'b0;
            else        be_ok_in  = 1'b0;
         end else if (is_high) begin
            be_low_in = 1'b1;
         end else if (is_low) begin
            be_ok_in = 1'b0;
         end
      end
      parity_in = ~parity_ff;

      av = ascii_ok_in;
      gv = gbk_ok_in & ~gbk_trail_in;
      uv = utf8_ok_in & (utf8_left_in == 2'd0);
      lv = le_ok_in & ~le_low_in & ~parity_in;
      bv = be_ok_in & ~be_low_in & ~parity_in;

      result.ascii_valid   = av;
      result.gbk_valid     = gv;
      result.utf8_valid    = uv;
      result.utf16le_valid = lv;
      result.utf16be_valid = bv;
      if (av)      result.charset = tcd_pkg::CharsetAnsi;
      else if (gv) result.charset = uv ? tcd_pkg::CharsetUtf8 : tcd_pkg::CharsetAnsi;
      else if (uv) result.charset = tcd_pkg::CharsetUtf8;
      else if (lv) result.charset = tcd_pkg::CharsetUtf16le;
      else if (bv) result.charset = tcd_pkg::CharsetUtf16be;
      else         result.charset = tcd_pkg::CharsetUnknown;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         ascii_ok_ff  <= 1'b1;
         gbk_ok_ff    <= 1'b1;
         gbk_trail_ff <= 1'b0;
         utf8_ok_ff   <= 1'b1;
         utf8_left_ff <= 2'd0;
         parity_ff    <= 1'b0;
         le_ok_ff     <= 1'b1;
         le_low_ff    <= 1'b0;
         be_ok_ff     <= 1'b1;
         be_low_ff    <= 1'b0;
      end else if (accept) begin
         ascii_ok_ff  <= ascii_ok_in;
         gbk_ok_ff    <= gbk_ok_in;
         gbk_trail_ff <= gbk_trail_in;
         utf8_ok_ff   <= utf8_ok_in;
         utf8_left_ff <= utf8_left_in;
         parity_ff    <= parity_in;
         le_ok_ff     <= le_ok_in;
         le_low_ff    <= le_low_in;
         be_ok_ff     <= be_ok_in;
         be_low_ff    <= be_low_in;
      end
   end

endmodule

>>> sv/text_charset_detector_top.sv
// ---------------------------------------------------------------------------
// text_charset_detector_top
// Streaming charset classifier for one text buffer at a time.
// ---------------------------------------------------------------------------
// Usage:
//   Feed the buffer one byte per transaction on the req_ channel, with
//   req_tlast high on the final byte. Non-final bytes only update the five
//   validators; the final byte yields one rsp_ transaction carrying the
//   charset class and the five validity flags, and clears the validators.
// Throughput and result path:
//   One byte is taken every cycle while req_tready is high. The final byte's
//   result is registered in the result register, or in the skid entry while
//   that is held; the validator logic is a few gates between state and result.
// Stall:
//   A result register plus one skid entry hold results while rsp_tready is
//   low. Bytes keep flowing until the skid entry is occupied; req_tready
//   then drops until the receiver drains it.
// Reset:
//   Synchronous, active high; clears the validators and both valid flags.
// ---------------------------------------------------------------------------
module text_charset_detector_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] charset, [3] ascii_valid, [4] gbk_valid,
                                   // [5] utf8_valid, [6] utf16le_valid, [7] utf16be_valid
);

   tcd_pkg::result_type result;
   tcd_pkg::result_type main_ff;
   tcd_pkg::result_type skid_ff;
   logic                main_valid_ff;
   logic                skid_valid_ff;
   logic                accept;
   logic                push;
   logic                pop;

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign push       = accept & req_tlast;
   assign pop        = main_valid_ff & rsp_tready;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_ff;

   tcd_validate u_validate (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) main_ff <= skid_ff;
      end else if (push) begin
         if (!main_valid_ff || pop) main_ff <= result;
         else                       skid_ff <= result;
      end
   end

endmodule

>>> test/charset_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charset_checker
// Watches both streams of the charset detector, runs its own copy of the
// five validators on every accepted byte and checks each result transaction
// field by field against the oldest predicted verdict.
// ---------------------------------------------------------------------------
module charset_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [2:0] charset, [3] ascii_valid, [4] gbk_valid,
                                   // [5] utf8_valid, [6] utf16le_valid, [7] utf16be_valid
   output int         mismatches,
   output int         outstanding
);

   localparam logic [7:0] GbkLeadLow   = 8'h81;
   localparam logic [7:0] GbkLeadHigh  = 8'hFE;
   localparam logic [7:0] GbkTrailLow  = 8'h40;
   localparam logic [7:0] GbkTrailHigh = 8'hFE;
   localparam logic [7:0] AsciiLimit   = 8'h80;
   localparam logic [7:0] SurrogateTop = 8'hFC;
   localparam logic [7:0] HighSurr     = 8'hD8;
   localparam logic [7:0] LowSurr      = 8'hDC;

   logic       ascii_clean;
   logic       gbk_clean;
   logic       gbk_need_trail;
   logic       utf8_clean;
   logic [1:0] utf8_pending;
   logic       odd_index;
   logic       le_clean;
   logic       le_need_low;
   logic       be_clean;
   logic       be_need_low;

   tcd_pkg::result_type pending_verdicts[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic clear_validators();
      ascii_clean    = 1'b1;
      gbk_clean      = 1'b1;
      gbk_need_trail = 1'b0;
      utf8_clean     = 1'b1;
      utf8_pending   = 2'd0;
      odd_index      = 1'b0;
      le_clean       = 1'b1;
      le_need_low    = 1'b0;
      be_clean       = 1'b1;
      be_need_low    = 1'b0;
   endtask

   task automatic pair_check(input logic [7:0] hi, inout logic ok, inout logic need_low);
      logic [7:0] top;
      top = hi & SurrogateTop;
      if (need_low) begin
         if (top == LowSurr) need_low = 1'b0;
         else ok = 1'b0;
      end else if (top == HighSurr) begin
         need_low = 1'b1;
      end else if (top == LowSurr) begin
         ok = 1'b0;
      end
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic last);
      tcd_pkg::result_type verdict;
      if (b >= AsciiLimit) ascii_clean = 1'b0;

      if (gbk_need_trail) begin
         if (b < GbkTrailLow || b > GbkTrailHigh) gbk_clean = 1'b0;
         gbk_need_trail = 1'b0;
      end else if (b >= AsciiLimit) begin
         if (b >= GbkLeadLow && b <= GbkLeadHigh) gbk_need_trail = 1'b1;
         else gbk_clean = 1'b0;
      end

      if (utf8_pending != 2'd0) begin
         if (b[7:6] == 2'b10) begin
            utf8_pending = utf8_pending - 2'd1;
         end else begin
            utf8_clean   = 1'b0;
            utf8_pending = 2'd0;
         end
      end else if (!b[7]) begin
      end else if (b[7:5] == 3'b110) begin
         utf8_pending = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         utf8_pending = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         utf8_pending = 2'd3;
      end else begin
         utf8_clean = 1'b0;
      end

      if (odd_index) pair_check(b, le_clean, le_need_low);
      else pair_check(b, be_clean, be_need_low);
      odd_index = ~odd_index;

      if (last) begin
         verdict.ascii_valid   = ascii_clean;
         verdict.gbk_valid     = gbk_clean && !gbk_need_trail;
         verdict.utf8_valid    = utf8_clean && utf8_pending == 2'd0;
         verdict.utf16le_valid = le_clean && !le_need_low && !odd_index;
         verdict.utf16be_valid = be_clean && !be_need_low && !odd_index;
         if (verdict.ascii_valid)
            verdict.charset = tcd_pkg::CharsetAnsi;
         else if (verdict.gbk_valid)
            verdict.charset = verdict.utf8_valid ? tcd_pkg::CharsetUtf8 : tcd_pkg::CharsetAnsi;
         else if (verdict.utf8_valid)
            verdict.charset = tcd_pkg::CharsetUtf8;
         else if (verdict.utf16le_valid)
            verdict.charset = tcd_pkg::CharsetUtf16le;
         else if (verdict.utf16be_valid)
            verdict.charset = tcd_pkg::CharsetUtf16be;
         else
            verdict.charset = tcd_pkg::CharsetUnknown;
         pending_verdicts = {pending_verdicts, verdict};
         clear_validators();
      end
   endtask

   task automatic compare_result(input tcd_pkg::result_type got);
      tcd_pkg::result_type want;
      if (pending_verdicts.size() == 0) begin
         report("result with nothing pending, charset", got.charset, 0);
         return;
      end
      want = pending_verdicts.pop_front();
      if (got.charset != want.charset) report("charset", got.charset, want.charset);
      if (got.ascii_valid != want.ascii_valid)
         report("ascii_valid", got.ascii_valid, want.ascii_valid);
      if (got.gbk_valid != want.gbk_valid)
         report("gbk_valid", got.gbk_valid, want.gbk_valid);
      if (got.utf8_valid != want.utf8_valid)
         report("utf8_valid", got.utf8_valid, want.utf8_valid);
      if (got.utf16le_valid != want.utf16le_valid)
         report("utf16le_valid", got.utf16le_valid, want.utf16le_valid);
      if (got.utf16be_valid != want.utf16be_valid)
         report("utf16be_valid", got.utf16be_valid, want.utf16be_valid);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_validators();
         pending_verdicts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_result(tcd_pkg::result_type'(rsp_tdata));
         if (req_tvalid && req_tready) absorb_byte(req_tdata, req_tlast);
      end
      outstanding <= pending_verdicts.size();
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Drives text buffers into the charset detector: a few hand-picked buffers
// for the edge cases, then random buffers of ASCII, GBK, UTF-8, UTF-16 and
// noise, some of them damaged, with random stalls on both streams.
// ---------------------------------------------------------------------------
module tb;

   typedef logic [7:0] text_queue_type[$];
   typedef enum int {TextAscii, TextGbk, TextUtf8, TextUtf16le, TextUtf16be, TextNoise}
      text_kind_type;

   localparam int RandomBytes = 2000;
   localparam int DrainPoint  = 1000;
   localparam int CalmPoint   = 1700;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;

   logic calm      = 1'b0;
   logic quiet     = 1'b0;
   int   hold_left = 0;
   int   mismatches;
   int   outstanding;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_charset_detector_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   charset_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic put_byte(input logic [7:0] b, input logic last);
      if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text(input text_queue_type text);
      foreach (text[i]) put_byte(text[i], i == text.size() - 1);
   endtask

   task automatic push_unit(inout text_queue_type text, input logic [15:0] unit,
                            input logic le);
      if (le) begin
         text = {text, unit[7:0]};
         text = {text, unit[15:8]};
      end else begin
         text = {text, unit[15:8]};
         text = {text, unit[7:0]};
      end
   endtask

   task automatic build_text(output text_queue_type text);
      text_kind_type kind;
      int            units;
      int            len;
      int            pos;
      logic [15:0]   unit;
      text  = {};
      kind  = text_kind_type'($urandom_range(0, 5));
      units = $urandom_range(1, 5);
      case (kind)
         TextAscii: begin
            repeat ($urandom_range(1, 10)) text = {text, 8'($urandom_range(0, 127))};
         end
         TextGbk: begin
            repeat (units) begin
               if ($urandom_range(0, 3) == 0) begin
                  text = {text, 8'($urandom_range(0, 127))};
               end else begin
                  text = {text, 8'($urandom_range(8'h81, 8'hFE))};
                  text = {text, 8'($urandom_range(8'h40, 8'hFE))};
               end
            end
         end
         TextUtf8: begin
            repeat (units) begin
               len = $urandom_range(1, 4);
               case (len)
                  1: text = {text, 8'($urandom_range(0, 127))};
                  2: text = {text, 8'hC0 | 8'($urandom_range(0, 31))};
                  3: text = {text, 8'hE0 | 8'($urandom_range(0, 15))};
                  default: text = {text, 8'hF0 | 8'($urandom_range(0, 7))};
               endcase
               repeat (len - 1) text = {text, 8'h80 | 8'($urandom_range(0, 63))};
            end
         end
         TextUtf16le, TextUtf16be: begin
            repeat (units) begin
               if ($urandom_range(0, 2) == 0) begin
                  unit = {6'b110110, 10'($urandom_range(0, 1023))};
                  push_unit(text, unit, kind == TextUtf16le);
                  unit = {6'b110111, 10'($urandom_range(0, 1023))};
               end else begin
                  do unit = 16'($urandom_range(0, 65535)); while (unit[15:11] == 5'b11011);
               end
               push_unit(text, unit, kind == TextUtf16le);
            end
         end
         default: begin
            repeat ($urandom_range(1, 8)) text = {text, 8'($urandom_range(0, 255))};
         end
      endcase
      if ($urandom_range(0, 4) == 0) begin
         pos = $urandom_range(0, text.size() - 1);
         case ($urandom_range(0, 2))
            0: if (text.size() > 1) void'(text.pop_back());
            1: text[pos] = 8'($urandom_range(0, 255));
            default: text = {text, 8'($urandom_range(0, 255))};
         endcase
      end
   endtask

   initial begin
      text_queue_type text;
      int             sent;
      logic           drained;
      sent    = 0;
      drained = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_text('{8'h00});
      send_text('{8'hFF});
      send_text('{8'h81, 8'h40});
      send_text('{8'hE4, 8'hB8, 8'hAD});
      send_text('{8'hD8, 8'h00, 8'hDC, 8'h00});
      send_text('{8'h3D, 8'hD8, 8'h00, 8'hDC});
      send_text('{8'h80, 8'hDC});
      send_text('{8'h41, 8'h81});
      send_text('{8'hF0, 8'h90});
      send_text('{8'h41, 8'hC3, 8'hA9});
      send_text('{8'h00, 8'hD8});

      while (sent < RandomBytes) begin
         if (!drained && sent >= DrainPoint) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
            drained = 1'b1;
         end
         if (sent >= CalmPoint) calm <= 1'b1;
         quiet = $urandom_range(0, 5) == 0;
         build_text(text);
         send_text(text);
         sent += text.size();
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
sv/tcd_pkg.sv
sv/tcd_validate.sv
sv/text_charset_detector_top.sv
test/charset_checker.sv
test/tb.sv
